FILE: hw/rtl/rtcs_pkg.sv
// Package for the ripple texture cell step unit.
// Holds format widths, register indexes, reset values and the saturation helper.
// No dependencies.
`default_nettype none

package rtcs_pkg;

  // Default grid side
  localparam int unsigned GRID_SIDE_DEF = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DROP_THRESHOLD = 3'd0,
    REG_DROP_STRENGTH  = 3'd1,
    REG_FALL_STEP      = 3'd2,
    REG_RISE_GAIN      = 3'd3,
    REG_CARRY_GAIN     = 3'd4,
    REG_SPREAD_GAIN    = 3'd5
  } cfg_reg_e;

  // Register reset values
  localparam logic [15:0] DROP_THRESHOLD_RST = 16'd3277;
  localparam logic [14:0] DROP_STRENGTH_RST  = 15'd2048;
  localparam logic [14:0] FALL_STEP_RST      = 15'd410;
  localparam logic [15:0] RISE_GAIN_RST      = 16'd3277;
  localparam logic [15:0] CARRY_GAIN_RST     = 16'd52429;
  localparam logic [15:0] SPREAD_GAIN_RST    = 16'd19859;

  // Stream payload widths
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;

  // Q3.12 value width and unit height
  localparam int unsigned VAL_W    = 16;
  localparam logic [12:0] HEIGHT_ONE = 13'd4096;

  // Pixel constants
  localparam logic [6:0] RED_BASE   = 7'd32;
  localparam logic [6:0] GREEN_BASE = 7'd64;
  localparam logic [7:0] BLUE_VALUE = 8'd255;
  localparam logic [7:0] ALPHA_BASE = 8'd146;

  // Saturate a wide signed value to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rtcs_ram.sv
// Generic synchronous RAM: one write port, NUM_RD registered read ports.
// Read data updates only on read enable. No dependencies.
`default_nettype none

module rtcs_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned NUM_RD = 1
) (
  input  wire  logic                     clk_i,
  input  wire  logic                     we_i,
  input  wire  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  logic [WIDTH-1:0]         wdata_i,
  input  wire  logic                     re_i,
  input  wire  logic [$clog2(DEPTH)-1:0] raddr_i [NUM_RD],
  output logic       [WIDTH-1:0]         rdata_o [NUM_RD]
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports
  for (genvar g = 0; g < NUM_RD; g++) begin : g_rd
    always_ff @(posedge clk_i) begin
      if (re_i) begin
        rdata_o[g] <= mem_q[raddr_i[g]];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ripple_texture_cell_step_unit.sv
// Ripple texture cell step unit: per-cell height, pressure and source update
// with RGBA pixel output. Depends on rtcs_pkg and rtcs_ram.
//
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: random_fraction[15:0]
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: red, green, blue, alpha
//                                                   tlast: frame_last
// cfg       in         cfg_we_i (no wait)           cfg_idx_i, cfg_data_i
//
// One cell per cycle sustained while m_axis_tready stays high; m_axis_tvalid comes
// from the output register after stage 4. The height memory has two read ports;
// with window registers holding the previous neighbors, each cell needs at most two
// new height reads. A clearing pass after reset writes zero to all memories with
// s_axis_tready low, over 2 * 2**clog2(GRID_SIDE*GRID_SIDE) addresses (512 at the
// default side); configuration writes are taken meanwhile.
// Each stage holds while the next is full, so bubbles close up under a stall.
`default_nettype none

module ripple_texture_cell_step_unit
  import rtcs_pkg::*;
#(
  parameter int unsigned GRID_SIDE = GRID_SIDE_DEF
) (
  input  wire  logic                   clk_i,
  input  wire  logic                   rst_ni,
  // Input stream
  input  wire  logic                   s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] random_fraction
  // Output stream
  output logic                         m_axis_tvalid,
  input  wire  logic                   m_axis_tready,
  // [6:0] red, [13:7] green, [21:14] blue, [29:22] alpha, [31:30] zero
  output logic [OUT_TDATA_W-1:0]       m_axis_tdata,
  output logic                         m_axis_tlast,   // frame_last
  // Configuration
  input  wire  logic                   cfg_we_i,
  input  wire  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned NUM_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int unsigned IW        = $clog2(NUM_CELLS);
  localparam int unsigned CW        = $clog2(GRID_SIDE);
  localparam int unsigned HA_W      = IW + 1;
  localparam int unsigned H_DEPTH   = 2 ** HA_W;
  localparam int unsigned P_DEPTH   = 2 ** IW;

  // Configuration registers
  logic [15:0] drop_threshold_q;
  logic [14:0] drop_strength_q;
  logic [14:0] fall_step_q;
  logic [15:0] rise_gain_q;
  logic [15:0] carry_gain_q;
  logic [15:0] spread_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_threshold_q <= DROP_THRESHOLD_RST;
      drop_strength_q  <= DROP_STRENGTH_RST;
      fall_step_q      <= FALL_STEP_RST;
      rise_gain_q      <= RISE_GAIN_RST;
      carry_gain_q     <= CARRY_GAIN_RST;
      spread_gain_q    <= SPREAD_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_DROP_THRESHOLD: drop_threshold_q <= cfg_data_i;
        REG_DROP_STRENGTH:  drop_strength_q  <= cfg_data_i[14:0];
        REG_FALL_STEP:      fall_step_q      <= cfg_data_i[14:0];
        REG_RISE_GAIN:      rise_gain_q      <= cfg_data_i;
        REG_CARRY_GAIN:     carry_gain_q     <= cfg_data_i;
        REG_SPREAD_GAIN:    spread_gain_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage handshake
  logic v1_q, v2_q, v3_q, v4_q, out_v_q;
  logic rdy_out, rdy4, rdy3, rdy2, rdy1;
  logic clr_done_q;
  logic acc;

  assign rdy_out       = !out_v_q || m_axis_tready;
  assign rdy4          = !v4_q || rdy_out;
  assign rdy3          = !v3_q || rdy4;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1 && clr_done_q;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // Cell position and bank
  logic [IW-1:0] idx_q;
  logic [CW-1:0] col_q;
  logic          bank_q;
  logic          last0, col_first0, col_last0;
  logic [IW-1:0] idx_next;

  assign last0      = (idx_q == IW'(NUM_CELLS - 1));
  assign col_first0 = (col_q == '0);
  assign col_last0  = (col_q == CW'(GRID_SIDE - 1));
  assign idx_next   = last0 ? '0 : idx_q + IW'(1);

  // Clearing pass after reset
  logic [HA_W-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_done_q <= 1'b0;
    end else if (!clr_done_q) begin
      clr_q <= clr_q + HA_W'(1);
      if (clr_q == '1) begin
        clr_done_q <= 1'b1;
      end
    end
  end

  // Advance position on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      col_q  <= '0;
      bank_q <= 1'b0;
    end else if (acc) begin
      idx_q  <= idx_next;
      col_q  <= col_last0 ? '0 : col_q + CW'(1);
      bank_q <= bank_q ^ last0;
    end
  end

  // Memories: heights with bank as top address bit, pressure and source packed
  logic [HA_W-1:0] h_raddr [2];
  logic [15:0]     h_rdata [2];
  logic            h_we;
  logic [HA_W-1:0] h_waddr;
  logic [15:0]     h_wdata;

  logic [IW-1:0]   p_raddr [1];
  logic [31:0]     p_rdata [1];
  logic            p_we;
  logic [IW-1:0]   p_waddr;
  logic [31:0]     p_wdata;

  // Port 0 looks one cell ahead, across the bank swap at frame end;
  // port 1 fetches the last column for the left neighbor of column zero
  assign h_raddr[0] = {last0 ? ~bank_q : bank_q, idx_next};
  assign h_raddr[1] = {bank_q, idx_q + IW'(GRID_SIDE - 1)};
  assign p_raddr[0] = idx_q;

  rtcs_ram #(
    .WIDTH  (VAL_W),
    .DEPTH  (H_DEPTH),
    .NUM_RD (2)
  ) u_height_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .re_i    (acc),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  rtcs_ram #(
    .WIDTH  (2 * VAL_W),
    .DEPTH  (P_DEPTH),
    .NUM_RD (1)
  ) u_press_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .re_i    (acc),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // Stage 1 registers: cell flags captured at acceptance
  logic          first1_q, lastcol1_q, last1_q, drop1_q, wbank1_q;
  logic [IW-1:0] idx1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      first1_q   <= col_first0;
      lastcol1_q <= col_last0;
      last1_q    <= last0;
      drop1_q    <= (s_axis_tdata[15:0] < drop_threshold_q);
      wbank1_q   <= ~bank_q;
      idx1_q     <= idx_q;
    end
  end

  // Stage 1: neighbor window and gain products
  logic signed [15:0] prev_c_q, prev_r_q, row0_q, first_q;
  logic signed [15:0] h_left, h_center, h_right;
  logic signed [17:0] sum3;
  logic signed [15:0] p1, s1;
  logic signed [16:0] spread_gs, carry_gs, rise_gs;
  logic signed [34:0] prod_sp;
  logic signed [32:0] prod_ca, prod_ri;
  logic signed [16:0] s_dec;
  logic signed [15:0] s_new;

  assign h_left   = first1_q   ? $signed(h_rdata[1]) : prev_c_q;
  assign h_center = first1_q   ? first_q             : prev_r_q;
  assign h_right  = lastcol1_q ? row0_q              : $signed(h_rdata[0]);
  assign sum3     = 18'(h_left) + 18'(h_center) + 18'(h_right);

  assign p1 = p_rdata[0][15:0];
  assign s1 = p_rdata[0][31:16];

  assign spread_gs = {1'b0, spread_gain_q};
  assign carry_gs  = {1'b0, carry_gain_q};
  assign rise_gs   = {1'b0, rise_gain_q};

  assign prod_sp = 35'(sum3) * 35'(spread_gs);
  assign prod_ca = 33'(p1) * 33'(carry_gs);
  assign prod_ri = 33'(s1) * 33'(rise_gs);

  // Source falls by a step, or restarts at drop strength
  assign s_dec = 17'(s1) - $signed({2'b00, fall_step_q});
  assign s_new = drop1_q ? $signed({1'b0, drop_strength_q}) : sat16(19'(s_dec));

  // Hold the window: first_q carries the next row's column zero, row0_q this row's
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
    end else if (v1_q && rdy2 && lastcol1_q) begin
      first_q <= $signed(h_rdata[0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      prev_c_q <= h_center;
      prev_r_q <= h_right;
      if (first1_q) begin
        row0_q <= h_center;
      end
    end
  end

  // Stage 2 registers: floored products and carried values
  logic signed [18:0] sp2_q;
  logic signed [16:0] ca2_q, ri2_q;
  logic signed [15:0] p2_q, s2_q;
  logic [IW-1:0]      idx2_q;
  logic               wbank2_q, last2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      sp2_q    <= prod_sp[34:16];
      ca2_q    <= prod_ca[32:16];
      ri2_q    <= prod_ri[32:16];
      p2_q     <= p1;
      s2_q     <= s_new;
      idx2_q   <= idx1_q;
      wbank2_q <= wbank1_q;
      last2_q  <= last1_q;
    end
  end

  // Stage 2: saturated sums and write-back
  logic signed [15:0] sc_sp, sc_ca, sc_ri, h_new, p_sum, p_new;
  logic [12:0]        m_val;

  assign sc_sp = sat16(sp2_q);
  assign sc_ca = sat16(19'(ca2_q));
  assign sc_ri = sat16(19'(ri2_q));
  assign h_new = sat16(19'(sc_sp) + 19'(sc_ca));
  assign p_sum = sat16(19'(p2_q) + 19'(sc_ri));
  assign p_new = (p_sum < 16'sd0) ? 16'sd0 : p_sum;

  // Clamp height to 0..1 for the color
  always_comb begin
    priority if (h_new < 16'sd0) begin
      m_val = '0;
    end else if (h_new > $signed({3'b000, HEIGHT_ONE})) begin
      m_val = HEIGHT_ONE;
    end else begin
      m_val = h_new[12:0];
    end
  end

  // Write port: clearing pass first, then stage 2 results
  assign h_we    = !clr_done_q || (v2_q && rdy3);
  assign h_waddr = clr_done_q ? {wbank2_q, idx2_q} : clr_q;
  assign h_wdata = clr_done_q ? h_new : '0;
  assign p_we    = h_we;
  assign p_waddr = clr_done_q ? idx2_q : clr_q[IW-1:0];
  assign p_wdata = clr_done_q ? {s2_q, p_new} : '0;

  // Stage 3: clamped height
  logic [12:0] m3_q;
  logic        last3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      m3_q    <= m_val;
      last3_q <= last2_q;
    end
  end

  // Stage 4: squared height, Q.24
  logic [24:0] sq4_q;
  logic        last4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      sq4_q   <= 25'(m3_q) * 25'(m3_q);
      last4_q <= last3_q;
    end
  end

  // Pixel channels: 32*sq is a shift, 50*sq a shift-add
  logic [30:0] sq50;
  logic [6:0]  red_d, green_d;
  logic [7:0]  alpha_d;

  assign sq50    = (31'(sq4_q) << 5) + (31'(sq4_q) << 4) + (31'(sq4_q) << 1);
  assign red_d   = RED_BASE + {1'b0, sq4_q[24:19]};
  assign green_d = GREEN_BASE + sq50[30:24];
  assign alpha_d = ALPHA_BASE + {1'b0, sq50[30:24]};

  // Output register
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                   out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (rdy_out) begin
      out_v_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out) begin
      out_data_q <= {2'b00, alpha_d, BLUE_VALUE, green_d, red_d};
      out_last_q <= last4_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
